// ===== rtl/fixed_block_pool_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fixed block pool allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`else

`define FBPA_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define FBPA_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/fbpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Fixed block pool allocator package
// Request and status codes, register indexes, sequencer states and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbpa_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_QUERY = 2'd3
    } fbpa_mode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_NOT_BLOCK    = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } fbpa_status_t;

    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

    localparam logic [31:0] BASE_RESET  = 32'd0;
    localparam logic [15:0] SIZE_RESET  = 16'd64;
    localparam logic [6:0]  COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } fbpa_state_t;

    typedef struct packed {
        logic load;     // latch a new request and restart the walk
        logic advance;  // step to the next block
        logic commit;   // write the result and update the flags
    } fbpa_cmd_t;

    typedef struct packed {
        logic finish;   // the current block ends the request
        logic out_free; // the result register can take a new result
    } fbpa_stat_t;

endpackage

// ===== rtl/fbpa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences accept, one flag read and one evaluation per visited block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  fbpa_stat_t stat,
    output fbpa_cmd_t  cmd
);

    fbpa_state_t state_reg;
    fbpa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.commit  = 1'b0;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                // A finished request waits here until the result register frees up.
                if (stat.finish) begin
                    if (stat.out_free) begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fbpa_datapath.sv =====
// ---------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Configuration registers, used-flag memory, block walk and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpa_datapath
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_address,
    input  fbpa_cmd_t   cmd,
    output fbpa_stat_t  stat,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_block_address,
    output logic [5:0]  m_block_index,
    output logic [6:0]  m_used_count
);

    // The count register is seven bits, so no more than 127 blocks are ever reachable.
    localparam int SAT_COUNT = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
    localparam int IDX_W     = (SAT_COUNT > 1) ? $clog2(SAT_COUNT) : 1;
    localparam int TOT_W     = $clog2(SAT_COUNT + 1);

    logic [31:0] base_reg;
    logic [15:0] size_reg;
    logic [6:0]  count_reg;

    fbpa_mode_t  mode_reg;
    logic [31:0] addr_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0] start_reg;
    logic [TOT_W-1:0] total_reg;

    logic flag_mem [SAT_COUNT];
    logic [SAT_COUNT-1:0] flag_vld_reg;
    logic rd_data_reg;
    logic rd_vld_reg;

    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] baddr_reg;
    logic [5:0]  bidx_reg;

    logic [6:0]  count_eff;
    logic [15:0] size_eff;
    logic        count_zero;
    logic        is_query;
    logic        is_alloc;
    logic        is_free;
    logic        flag;
    logic        hit;
    logic        eff_hit;
    logic        last;
    logic [7:0]  idx_p1;
    logic        flag_we;
    logic        flag_wdata;
    fbpa_status_t status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RESET;
            size_reg  <= SIZE_RESET;
            count_reg <= COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_reg  <= cfg_wdata;
                REG_BLOCK_SIZE:   size_reg  <= cfg_wdata[15:0];
                REG_BLOCK_COUNT:  count_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign count_eff  = (count_reg > 7'(SAT_COUNT)) ? 7'(SAT_COUNT) : count_reg;
    assign size_eff   = (size_reg == 16'd0) ? 16'd1 : size_reg;
    assign count_zero = (count_eff == 7'd0);

    assign is_query = (mode_reg == MODE_QUERY);
    assign is_alloc = (mode_reg == MODE_ALLOC);
    assign is_free  = (mode_reg == MODE_FREE);

    // A flag that was never written reads as free.
    assign flag    = rd_vld_reg & rd_data_reg;
    assign hit     = is_alloc ? !flag : (start_reg == addr_reg);
    assign eff_hit = !is_query && !count_zero && hit;
    assign idx_p1  = 8'(idx_reg) + 8'd1;
    assign last    = (idx_p1 == {1'b0, count_eff});

    assign stat.finish   = is_query || count_zero || hit || last;
    assign stat.out_free = !m_valid_reg || m_ready;

    // Request latch and block walk. The start address advances by one add per block.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= fbpa_mode_t'(s_mode);
            addr_reg  <= s_address;
            idx_reg   <= '0;
            start_reg <= base_reg;
        end else if (cmd.advance) begin
            idx_reg   <= idx_reg + IDX_W'(1);
            start_reg <= start_reg + {16'd0, size_eff};
        end
    end

    assign flag_we    = cmd.commit && eff_hit && (is_alloc || (is_free && flag));
    assign flag_wdata = is_alloc;

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[idx_reg] <= flag_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= flag_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= flag_vld_reg[idx_reg];
            if (flag_we) begin
                flag_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (flag_we) begin
            if (is_alloc) begin
                total_reg <= total_reg + TOT_W'(1);
            end else begin
                total_reg <= total_reg - TOT_W'(1);
            end
        end
    end

    always_comb begin
        if (is_query) begin
            status_next = ST_OK;
        end else if (!eff_hit) begin
            status_next = is_alloc ? ST_FULL : ST_NOT_BLOCK;
        end else if (is_free && !flag) begin
            status_next = ST_ALREADY_FREE;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg <= status_next;
            baddr_reg  <= (eff_hit && is_alloc) ? start_reg : 32'd0;
            bidx_reg   <= eff_hit ? 6'(idx_reg) : 6'd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_block_address = baddr_reg;
    assign m_block_index   = bidx_reg;
    assign m_used_count    = 7'(total_reg);

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// A request walks the pool block by block: up to the first free one for allocate, up to the
// matching start for free and check, all blocks when nothing is found, and a single block for
// query or an empty pool. The result is registered when the walk ends, and it is presented
// and the input reopens in the same cycle. The walk is serial: each block takes one
// registered read of the used-flag memory and one 32-bit add that forms the next block start.
// The result is held in an output register, so a new request is taken while the previous result
// still waits to be transferred; a stalled result only delays the end of the next walk.
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// Fixed block pool allocator
// First-fit allocator over a pool of equal-sized blocks with a used count.
// ---------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_block_address,
    output logic [5:0]  m_block_index,
    output logic [6:0]  m_used_count
);

    localparam int SAT_COUNT = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;

    fbpa_cmd_t  cmd;
    fbpa_stat_t stat;

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_mode          (s_mode),
        .s_address       (s_address),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .m_block_index   (m_block_index),
        .m_used_count    (m_used_count)
    );

    // Only one request is in flight, so the input closes right after a transfer.
    `FBPA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A result is never written over one that has not been transferred.
    `FBPA_ASSERT_SAME(a_commit_room, aclk, aresetn, cmd.commit, stat.out_free)
    `FBPA_ASSERT_NEXT(a_commit_shows, aclk, aresetn, cmd.commit, m_valid)
    `FBPA_ASSERT_SAME(a_count_bound, aclk, aresetn, m_valid, m_used_count <= 7'(SAT_COUNT))

endmodule

// ===== tb/tb_fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate, free, check and query requests through the valid/ready
// request channel under several pool settings and idle patterns. Every result
// transfer is compared against an in-bench model of the pool or a directed row's expected result.
// ---------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int POOL_MAX        = 64;
    localparam int GROUPS          = 8;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int DIRECTED_ROWS   = 14;
    localparam int SETTLE_CYCLES   = 140;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_REPORTS     = 10;

    // The register file decodes only three indexes; this one must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        fbpa_status_t status;
        logic [31:0]  block_address;
        logic [5:0]   block_index;
        logic [6:0]   used_count;
    } pool_result_t;

    typedef struct {
        fbpa_mode_t   mode;
        logic [31:0]  address;
        bit           typed;
        pool_result_t result;
    } directed_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_BASE_ADDRESS;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode    = MODE_QUERY;
    logic [31:0] s_address = 32'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_block_address;
    logic [5:0]  m_block_index;
    logic [6:0]  m_used_count;

    // Model of the pool.
    logic        block_used [POOL_MAX];
    logic [6:0]  blocks_in_use    = 7'd0;
    logic [31:0] pool_base        = BASE_RESET;
    logic [15:0] pool_block_size  = SIZE_RESET;
    logic [6:0]  pool_block_count = COUNT_RESET;

    pool_result_t pending_results[$];
    int           mismatch_count  = 0;
    int           cycle_count     = 0;
    int           sender_idle_pct = 0;
    int           sink_stall_pct  = 0;

    logic [31:0] group_base      [GROUPS] = '{32'h0000_0000, 32'hFFFF_FFC0, 32'h0000_0000,
                                              32'h1234_5678, 32'hFFFF_0000, 32'hA5A5_0000,
                                              32'hFFFF_FFFF, 32'h8000_0000};
    logic [15:0] group_size      [GROUPS] = '{16'd64, 16'd16, 16'd1, 16'd0, 16'd65535,
                                              16'd100, 16'd3, 16'd64};
    logic [6:0]  group_count     [GROUPS] = '{7'd64, 7'd8, 7'd127, 7'd5, 7'd64, 7'd0,
                                              7'd1, 7'd64};
    int          group_alloc_pct [GROUPS] = '{45, 60, 55, 50, 70, 40, 50, 30};

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_QUERY, 32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 6'd0, 7'd0}},
        '{MODE_CHECK, 32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 6'd0, 7'd0}},
        '{MODE_FREE,  32'h0000_0000, 1'b1, '{ST_ALREADY_FREE, 32'd0, 6'd0, 7'd0}},
        '{MODE_FREE,  32'h0000_0001, 1'b1, '{ST_NOT_BLOCK, 32'd0, 6'd0, 7'd0}},
        '{MODE_CHECK, 32'hFFFF_FFFF, 1'b1, '{ST_NOT_BLOCK, 32'd0, 6'd0, 7'd0}},
        '{MODE_ALLOC, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'd0, 6'd0, 7'd1}},
        '{MODE_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK, 32'd64, 6'd1, 7'd2}},
        '{MODE_CHECK, 32'h0000_0040, 1'b0, '0},
        '{MODE_FREE,  32'h0000_0000, 1'b0, '0},
        '{MODE_ALLOC, 32'h5555_AAAA, 1'b0, '0},
        '{MODE_CHECK, 32'h0000_0FC0, 1'b1, '{ST_OK, 32'd0, 6'd63, 7'd2}},
        '{MODE_FREE,  32'h0000_0FC0, 1'b1, '{ST_ALREADY_FREE, 32'd0, 6'd63, 7'd2}},
        '{MODE_CHECK, 32'h0000_1000, 1'b1, '{ST_NOT_BLOCK, 32'd0, 6'd0, 7'd2}},
        '{MODE_QUERY, 32'hFFFF_FFFF, 1'b0, '0}
    };

    fixed_block_pool_allocator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .m_block_index   (m_block_index),
        .m_used_count    (m_used_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int reachable_blocks();
        return (pool_block_count > 7'(POOL_MAX)) ? POOL_MAX : int'(pool_block_count);
    endfunction

    function automatic int block_step();
        return (pool_block_size == 16'd0) ? 1 : int'(pool_block_size);
    endfunction

    // Start addresses wrap modulo 2^32.
    function automatic logic [31:0] start_of(int idx);
        return pool_base + 32'(idx) * 32'(block_step());
    endfunction

    function automatic pool_result_t serve_request(fbpa_mode_t mode, logic [31:0] addr);
        pool_result_t r;
        int           n;
        int           hit;
        r   = '0;
        n   = reachable_blocks();
        hit = -1;
        case (mode)
            MODE_ALLOC: begin
                for (int i = 0; i < n; i++)
                    if (hit < 0 && !block_used[i]) hit = i;
                if (hit < 0) begin
                    r.status = ST_FULL;
                end else begin
                    block_used[hit] = 1'b1;
                    blocks_in_use   = blocks_in_use + 7'd1;
                    r.block_address = start_of(hit);
                    r.block_index   = hit[5:0];
                end
            end
            MODE_FREE, MODE_CHECK: begin
                for (int i = 0; i < n; i++)
                    if (hit < 0 && start_of(i) == addr) hit = i;
                if (hit < 0) begin
                    r.status = ST_NOT_BLOCK;
                end else begin
                    r.block_index = hit[5:0];
                    if (mode == MODE_FREE) begin
                        if (block_used[hit]) begin
                            block_used[hit] = 1'b0;
                            blocks_in_use   = blocks_in_use - 7'd1;
                        end else begin
                            r.status = ST_ALREADY_FREE;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.used_count = blocks_in_use;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the write.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_BASE_ADDRESS: pool_base        = data;
            REG_BLOCK_SIZE:   pool_block_size  = data[15:0];
            REG_BLOCK_COUNT:  pool_block_count = data[6:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_pool_config(input logic [31:0] base, input logic [15:0] size,
                                   input logic [6:0] count);
        logic [31:0] noise;
        noise = $urandom();
        // Upper bits of the narrow registers carry junk that must be dropped.
        write_register(REG_BASE_ADDRESS, base);
        write_register(REG_BLOCK_SIZE, {noise[31:16], size});
        write_register(REG_BLOCK_COUNT, {noise[24:0], count});
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input fbpa_mode_t mode, input logic [31:0] addr,
                                input bit typed, input pool_result_t typed_result);
        pool_result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        predicted = serve_request(mode, addr);
        pending_results.push_back(typed ? typed_result : predicted);
        @(negedge aclk);
    endtask

    // Hold the request channel idle until every result has been transferred.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic pick_request(input int alloc_pct, output fbpa_mode_t mode,
                                output logic [31:0] addr);
        int roll;
        int pick;
        int n;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        n    = reachable_blocks();
        addr = $urandom();
        if (roll < alloc_pct) begin
            mode = MODE_ALLOC;
            return;
        end else if (roll < alloc_pct + (100 - alloc_pct) * 6 / 10) begin
            mode = MODE_FREE;
        end else if (roll < alloc_pct + (100 - alloc_pct) * 8 / 10) begin
            mode = MODE_CHECK;
        end else begin
            mode = MODE_QUERY;
            return;
        end
        // Mostly real block starts; some off-by-a-few or past the pool; some noise.
        if (n > 0 && pick < 75)
            addr = start_of($urandom_range(0, n - 1));
        else if (pick < 88)
            addr = start_of($urandom_range(0, POOL_MAX - 1))
                   + ((block_step() > 1) ? 32'($urandom_range(1, block_step() - 1)) : 32'd0);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge aclk) begin : result_monitor
        pool_result_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result transfer with no request outstanding", $realtime);
            end else begin
                expected = pending_results.pop_front();
                if (m_status !== expected.status || m_block_address !== expected.block_address
                    || m_block_index !== expected.block_index
                    || m_used_count !== expected.used_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected status %0d addr %h index %0d used %0d,",
                                  " got status %0d addr %h index %0d used %0d"},
                                 $realtime, expected.status, expected.block_address,
                                 expected.block_index, expected.used_count, m_status,
                                 m_block_address, m_block_index, m_used_count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL fixed_block_pool_allocator");
            $finish;
        end
    end

    initial begin : stimulus
        fbpa_mode_t  mode;
        logic [31:0] addr;
        logic [31:0] base;
        for (int i = 0; i < POOL_MAX; i++) block_used[i] = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].address,
                         directed_rows[i].typed, directed_rows[i].result);

        for (int g = 0; g < GROUPS; g++) begin
            wait_for_drain();
            repeat (8) @(negedge aclk);
            // One setting uses a fresh base each run.
            base = (g == 2) ? $urandom() : group_base[g];
            if (g == 3) write_register(REG_UNUSED, $urandom());
            set_pool_config(base, group_size[g], group_count[g]);
            @(negedge aclk);
            for (int p = 0; p < 4; p++) begin
                case (p)
                    0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                    1: begin sender_idle_pct = 74; sink_stall_pct = 0;  end
                    2: begin sender_idle_pct = 0;  sink_stall_pct = 74; end
                    default: begin sender_idle_pct = 22; sink_stall_pct = 22; end
                endcase
                for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                    if ($urandom_range(0, 99) == 0) wait_for_drain();
                    pick_request(group_alloc_pct[g], mode, addr);
                    send_request(mode, addr, 1'b0, '0);
                end
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS fixed_block_pool_allocator");
        else
            $display("FAIL fixed_block_pool_allocator");
        $finish;
    end

endmodule
